>>> design/utf8_stream_sanitizer_core_defines.svh
// Assertion macros shared by the sanitizer RTL.
`ifndef UTF8_STREAM_SANITIZER_CORE_DEFINES_SVH
`define UTF8_STREAM_SANITIZER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled in reset.
`define UTF8SS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8ss assertion failed");
// Next-cycle implication, disabled in reset.
`define UTF8SS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8ss assertion failed");
`else
`define UTF8SS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UTF8SS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/utf8ss_pkg.sv
// Types and constants shared by the UTF-8 stream sanitizer modules.
`timescale 1ns / 1ps

package utf8ss_pkg;

    // One input transaction.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } utf8ss_in_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       text_done;
        logic       replaced;
    } utf8ss_out_t;

    // A run of output bytes, right-aligned in seq, first byte most significant.
    typedef struct packed {
        logic [31:0] seq;
        logic [1:0]  last_idx;
        logic        repl;
        logic        done;
    } utf8ss_run_t;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] REPL_SEQ      = 32'h00EF_BFBD;
    localparam logic [1:0]  REPL_LAST_IDX = 2'd2;

endpackage

>>> design/utf8_stream_sanitizer_core.sv
// Top level of the UTF-8 stream sanitizer.
`timescale 1ns / 1ps
`include "utf8_stream_sanitizer_core_defines.svh"

// Cleans a UTF-8 byte stream one byte per cycle. A byte is accepted in any
// cycle in which full is low; full rises only when the four-entry run queue
// between the front end and the byte emitter is full. Each accepted byte
// yields zero to four output bytes (a valid sequence, or EF BF BD for a bad
// lead byte, an invalid sequence or a sequence cut short by end_of_text).
// Output leaves from the output register at one byte per cycle while pop is
// held high; the run of an accepted byte is written into the run queue and its
// bytes then load into the output register as it frees up. After a
// byte with end_of_text set, the next byte starts a new text.
module utf8_stream_sanitizer_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  utf8ss_pkg::utf8ss_in_t  item,
    output logic                    empty,
    input  logic                    pop,
    output utf8ss_pkg::utf8ss_out_t result
);
    import utf8ss_pkg::*;

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    utf8ss_run_t q_wdata;
    utf8ss_run_t q_head;

    assign full = q_full;

    utf8ss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .q_full   (q_full),
        .run_push (q_push),
        .run      (q_wdata)
    );

    utf8ss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    utf8ss_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

    `UTF8SS_ASSERT_NOW(a_push_has_room, clk, rst_n, q_push, !q_full)
    `UTF8SS_ASSERT_NOW(a_pop_has_run, clk, rst_n, q_pop, !q_empty)
    `UTF8SS_ASSERT_NOW(a_done_ends_run, clk, rst_n, !empty && result.text_done, result.last_of_run)
    `UTF8SS_ASSERT_NOW(a_repl_ends_bd, clk, rst_n, !empty && result.replaced && result.out_byte == 8'hBD, result.last_of_run)

endmodule

>>> design/utf8ss_front.sv
// Front end: accepts text bytes, assembles sequences and classifies each run.
`timescale 1ns / 1ps

module utf8ss_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  utf8ss_pkg::utf8ss_in_t item,
    input  logic                   q_full,
    output logic                   run_push,
    output utf8ss_pkg::utf8ss_run_t run
);
    import utf8ss_pkg::*;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        priority if (b[7] == 1'b0)       len = 3'd1;
        else if (b[7:5] == 3'b110)        len = 3'd2;
        else if (b[7:4] == 4'b1110)       len = 3'd3;
        else if (b[7:3] == 5'b11110)      len = 3'd4;
        else                              len = 3'd0;
        return len;
    endfunction

    function automatic logic valid_seq(input logic [31:0] e);
        logic ok;
        priority if (e <= 32'h0000_007F)
            ok = 1'b1;
        else if (e >= 32'h0000_C280 && e <= 32'h0000_DFBF)
            ok = (e & 32'h0000_E0C0) == 32'h0000_C080;
        else if (e >= 32'h00ED_A080 && e <= 32'h00ED_BFBF)
            ok = 1'b0;
        else if (e >= 32'h00E0_A080 && e <= 32'h00EF_BFBF)
            ok = (e & 32'h00F0_C0C0) == 32'h00E0_8080;
        else if (e >= 32'hF090_8080 && e <= 32'hF48F_BFBF)
            ok = (e & 32'hF8C0_C0C0) == 32'hF080_8080;
        else
            ok = 1'b0;
        return ok;
    endfunction

    logic [23:0] part_reg, part_next;
    logic [2:0]  exp_reg, exp_next;
    logic [1:0]  coll_reg, coll_next;

    logic        accept;
    logic [2:0]  len;
    logic [2:0]  held;
    logic [2:0]  len_m1;
    logic [31:0] e;

    assign accept = push && !q_full;
    assign len    = lead_len(item.text_byte);
    assign held   = {1'b0, coll_reg} + 3'd1;
    assign len_m1 = exp_reg - 3'd1;
    assign e      = {part_reg, item.text_byte};

    always_comb
    begin
        part_next    = part_reg;
        exp_next     = exp_reg;
        coll_next    = coll_reg;
        run_push     = 1'b0;
        run.seq      = REPL_SEQ;
        run.last_idx = REPL_LAST_IDX;
        run.repl     = 1'b1;
        run.done     = item.end_of_text;

        if (accept)
        begin
            if (exp_reg == 3'd0)
            begin
                if (len == 3'd0)
                begin
                    run_push = 1'b1;
                end
                else if (len == 3'd1)
                begin
                    run_push     = 1'b1;
                    run.seq      = {24'd0, item.text_byte};
                    run.last_idx = 2'd0;
                    run.repl     = 1'b0;
                end
                else
                begin
                    part_next = {16'd0, item.text_byte};
                    exp_next  = len;
                    coll_next = 2'd1;
                end
            end
            else if (held >= exp_reg)
            begin
                run_push = 1'b1;
                if (valid_seq(e))
                begin
                    run.seq      = e;
                    run.last_idx = len_m1[1:0];
                    run.repl     = 1'b0;
                end
                part_next = 24'd0;
                exp_next  = 3'd0;
                coll_next = 2'd0;
            end
            else
            begin
                part_next = {part_reg[15:0], item.text_byte};
                coll_next = held[1:0];
            end

            // End of text: drop an open sequence with a replacement run.
            if (item.end_of_text)
            begin
                if (exp_next != 3'd0)
                begin
                    run_push = 1'b1;
                end
                part_next = 24'd0;
                exp_next  = 3'd0;
                coll_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= 24'd0;
            exp_reg  <= 3'd0;
            coll_reg <= 2'd0;
        end
        else
        begin
            part_reg <= part_next;
            exp_reg  <= exp_next;
            coll_reg <= coll_next;
        end
    end

endmodule

>>> design/utf8ss_queue.sv
// Short run queue between the front end and the byte emitter.
`timescale 1ns / 1ps

module utf8ss_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_push,
    input  utf8ss_pkg::utf8ss_run_t q_wdata,
    input  logic                    q_pop,
    output utf8ss_pkg::utf8ss_run_t q_head,
    output logic                    q_full,
    output logic                    q_empty
);
    import utf8ss_pkg::*;

    utf8ss_run_t       slot_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QIDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_empty = count_reg == '0;
    assign q_head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + QIDX_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + QIDX_W'(1);
        end
        unique case ({q_push, q_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            slot_reg[wr_ptr_reg] <= q_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/utf8ss_back.sv
// Back end: expands queued runs into bytes through an output register.
`timescale 1ns / 1ps

module utf8ss_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  utf8ss_pkg::utf8ss_run_t q_head,
    input  logic                    q_empty,
    output logic                    q_pop,
    output utf8ss_pkg::utf8ss_out_t result,
    output logic                    empty,
    input  logic                    pop
);
    import utf8ss_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    utf8ss_out_t out_reg, out_next;
    logic        valid_reg, valid_next;

    logic        load;
    logic        at_last;
    logic [1:0]  shift;
    logic [7:0]  sel_byte;

    assign load    = (!valid_reg || pop) && !q_empty;
    assign at_last = idx_reg == q_head.last_idx;
    assign shift   = q_head.last_idx - idx_reg;
    assign q_pop   = load && at_last;
    assign result  = out_reg;
    assign empty   = !valid_reg;

    always_comb
    begin
        unique case (shift)
            2'd0:    sel_byte = q_head.seq[7:0];
            2'd1:    sel_byte = q_head.seq[15:8];
            2'd2:    sel_byte = q_head.seq[23:16];
            default: sel_byte = q_head.seq[31:24];
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        out_next   = out_reg;
        valid_next = valid_reg;
        if (load)
        begin
            out_next.out_byte    = sel_byte;
            out_next.last_of_run = at_last;
            out_next.text_done   = at_last && q_head.done;
            out_next.replaced    = q_head.repl;
            valid_next           = 1'b1;
            // Advance within the run, restart at the next one.
            idx_next             = at_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule

>>> dv/tb_utf8_stream_sanitizer_core.sv
// Self-checking testbench for the UTF-8 stream sanitizer core.
`timescale 1ns / 1ps

module tb_utf8_stream_sanitizer_core;
    import utf8ss_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 285;
    localparam int unsigned DRAIN_PAUSE_AT = 140;
    localparam int unsigned HOLD_AT_RESULT = 100;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Range and form limits of well-formed UTF-8, packed first byte high.
    localparam logic [31:0] ASCII_MAX  = 32'h0000_007F;
    localparam logic [31:0] TWO_MIN    = 32'h0000_C280;
    localparam logic [31:0] TWO_MAX    = 32'h0000_DFBF;
    localparam logic [31:0] TWO_MASK   = 32'h0000_E0C0;
    localparam logic [31:0] TWO_FORM   = 32'h0000_C080;
    localparam logic [31:0] SURR_MIN   = 32'h00ED_A080;
    localparam logic [31:0] SURR_MAX   = 32'h00ED_BFBF;
    localparam logic [31:0] THREE_MIN  = 32'h00E0_A080;
    localparam logic [31:0] THREE_MAX  = 32'h00EF_BFBF;
    localparam logic [31:0] THREE_MASK = 32'h00F0_C0C0;
    localparam logic [31:0] THREE_FORM = 32'h00E0_8080;
    localparam logic [31:0] FOUR_MIN   = 32'hF090_8080;
    localparam logic [31:0] FOUR_MAX   = 32'hF48F_BFBF;
    localparam logic [31:0] FOUR_MASK  = 32'hF8C0_C0C0;
    localparam logic [31:0] FOUR_FORM  = 32'hF080_8080;

    localparam logic [23:0] REPL_BYTES = 24'hEF_BFBD;

    // Sequences on either side of each range limit.
    localparam logic [31:0] BOUNDARY_SEQS [18] = '{
        32'h0000_0000, 32'h0000_007F, 32'h0000_C280, 32'h0000_DFBF,
        32'h0000_C1BF, 32'h0000_C080, 32'h00E0_A080, 32'h00E0_9FBF,
        32'h00EF_BFBF, 32'h00ED_9FBF, 32'h00ED_A080, 32'h00ED_BFBF,
        32'h00EE_8080, 32'hF090_8080, 32'hF08F_BFBF, 32'hF48F_BFBF,
        32'hF490_8080, 32'hF580_8080
    };

    // One stimulus row; fixed rows carry their expected bytes typed in.
    typedef struct packed {
        logic [7:0]  text_b;
        logic        eot;
        logic        fixed;
        logic [1:0]  n_fixed;
        logic [23:0] fixed_bytes;
        logic        fixed_repl;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    utf8ss_in_t  item = '0;
    utf8ss_out_t result;

    // Predictor state.
    logic [23:0] open_bytes = '0;
    logic [2:0]  open_len = '0;
    logic [1:0]  open_held = '0;

    utf8ss_out_t step_out[$];
    utf8ss_out_t clean_bytes_q[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          push_burst = 1'b0;
    bit          pop_burst = 1'b0;
    stim_row_t   directed_rows [0:25];

    utf8_stream_sanitizer_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        casez (b)
            8'b0???????: return 3'd1;
            8'b110?????: return 3'd2;
            8'b1110????: return 3'd3;
            8'b11110???: return 3'd4;
            default:     return 3'd0;
        endcase
    endfunction

    function automatic bit seq_ok(input logic [31:0] e);
        if (e <= ASCII_MAX) return 1'b1;
        if (e >= TWO_MIN && e <= TWO_MAX) return (e & TWO_MASK) == TWO_FORM;
        if (e >= SURR_MIN && e <= SURR_MAX) return 1'b0;
        if (e >= THREE_MIN && e <= THREE_MAX) return (e & THREE_MASK) == THREE_FORM;
        if (e >= FOUR_MIN && e <= FOUR_MAX) return (e & FOUR_MASK) == FOUR_FORM;
        return 1'b0;
    endfunction

    task automatic add_byte(input logic [7:0] v, input logic repl);
        utf8ss_out_t r;
        r = '{out_byte: v, last_of_run: 1'b0, text_done: 1'b0, replaced: repl};
        step_out.push_back(r);
    endtask

    task automatic add_repl();
        add_byte(8'hEF, 1'b1);
        add_byte(8'hBF, 1'b1);
        add_byte(8'hBD, 1'b1);
    endtask

    task automatic mark_last(input logic eot);
        if (step_out.size() > 0)
        begin
            step_out[step_out.size() - 1].last_of_run = 1'b1;
            step_out[step_out.size() - 1].text_done = eot;
        end
    endtask

    // Work out the output bytes of one accepted text byte into step_out.
    task automatic sanitize_step(input logic [7:0] b, input logic eot);
        logic [31:0] e;
        logic [2:0]  len;
        int          k;
        step_out.delete();
        if (open_len == 3'd0)
        begin
            len = lead_len(b);
            if (len == 3'd0)
                add_repl();
            else if (len == 3'd1)
                add_byte(b, 1'b0);
            else
            begin
                open_bytes = {16'h0, b};
                open_len = len;
                open_held = 2'd1;
            end
        end
        else if ({1'b0, open_held} + 3'd1 >= open_len)
        begin
            e = {open_bytes, b};
            if (seq_ok(e))
            begin
                for (k = 0; k < int'(open_len); k++)
                    add_byte(e[8 * (int'(open_len) - 1 - k) +: 8], 1'b0);
            end
            else
                add_repl();
            open_bytes = '0;
            open_len = '0;
            open_held = '0;
        end
        else
        begin
            open_bytes = {open_bytes[15:0], b};
            open_held = open_held + 2'd1;
        end
        if (eot)
        begin
            // Drop a sequence cut short by the end of text.
            if (open_len != 3'd0) add_repl();
            open_bytes = '0;
            open_len = '0;
            open_held = '0;
        end
        mark_last(eot);
    endtask

    // Offer one row, hold it until accepted, then queue its expected bytes.
    task automatic send_row(input stim_row_t r);
        int gap;
        int k;
        gap = push_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{text_byte: r.text_b, end_of_text: r.eot};
        @(posedge clk);
        while (full) @(posedge clk);
        sanitize_step(r.text_b, r.eot);
        if (r.fixed)
        begin
            step_out.delete();
            for (k = 0; k < int'(r.n_fixed); k++)
                add_byte(r.fixed_bytes[8 * (int'(r.n_fixed) - 1 - k) +: 8], r.fixed_repl);
            mark_last(r.eot);
        end
        foreach (step_out[i]) clean_bytes_q.push_back(step_out[i]);
    endtask

    // Build one random chunk of text, mostly well-formed, and send it.
    task automatic send_random_chunk(inout int sent);
        logic [7:0]  seq_b [4];
        logic [31:0] e;
        stim_row_t   r;
        int          len;
        int          pick;
        int          eot_at;
        int          k;
        pick = $urandom_range(0, 99);
        len = 1;
        for (k = 0; k < 4; k++) seq_b[k] = 8'h80 | 8'($urandom_range(0, 63));
        if (pick < 70)
        begin
            len = $urandom_range(1, 4);
            case (len)
                1: seq_b[0] = 8'($urandom_range(8'h00, 8'h7F));
                2: seq_b[0] = 8'($urandom_range(8'hC2, 8'hDF));
                3:
                begin
                    seq_b[0] = 8'($urandom_range(8'hE0, 8'hEF));
                    if (seq_b[0] == 8'hE0) seq_b[1] = 8'($urandom_range(8'hA0, 8'hBF));
                    if (seq_b[0] == 8'hED) seq_b[1] = 8'($urandom_range(8'h80, 8'h9F));
                end
                default:
                begin
                    seq_b[0] = 8'($urandom_range(8'hF0, 8'hF4));
                    if (seq_b[0] == 8'hF0) seq_b[1] = 8'($urandom_range(8'h90, 8'hBF));
                    if (seq_b[0] == 8'hF4) seq_b[1] = 8'($urandom_range(8'h80, 8'h8F));
                end
            endcase
            // Corrupt one byte of some well-formed sequences.
            if (pick >= 55) seq_b[$urandom_range(0, len - 1)] = 8'($urandom);
        end
        else if (pick < 82)
        begin
            e = BOUNDARY_SEQS[$urandom_range(0, 17)];
            len = (e[31:24] != 0) ? 4 : (e[23:16] != 0) ? 3 : (e[15:8] != 0) ? 2 : 1;
            for (k = 0; k < len; k++) seq_b[k] = e[8 * (len - 1 - k) +: 8];
        end
        else if (pick < 90)
            seq_b[0] = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                             : 8'($urandom_range(8'hF8, 8'hFF));
        else
        begin
            len = $urandom_range(1, 4);
            for (k = 0; k < len; k++) seq_b[k] = 8'($urandom);
        end
        // Mostly no end of text; sometimes at the end, sometimes cutting short.
        pick = $urandom_range(0, 9);
        eot_at = (pick == 0) ? $urandom_range(0, len - 1) : (pick == 1) ? len - 1 : -1;
        if (eot_at >= 0) len = eot_at + 1;
        for (k = 0; k < len; k++)
        begin
            r = '{text_b: seq_b[k], eot: (k == eot_at), fixed: 1'b0, n_fixed: 2'd0,
                  fixed_bytes: 24'h0, fixed_repl: 1'b0};
            send_row(r);
            sent++;
            if (sent % 40 == 0) push_burst = ($urandom_range(0, 2) == 0);
        end
    endtask

    // Compare every popped transaction with the oldest expected byte.
    always @(posedge clk)
    begin
        utf8ss_out_t want;
        if (rst_n && pop && !empty)
        begin
            if (clean_bytes_q.size() == 0)
            begin
                $error("unexpected output byte %h", result.out_byte);
                mismatch_count++;
            end
            else
            begin
                want = clean_bytes_q.pop_front();
                if (result.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, result.out_byte);
                    mismatch_count++;
                end
                if (result.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %b, got %b", want.last_of_run,
                           result.last_of_run);
                    mismatch_count++;
                end
                if (result.text_done !== want.text_done)
                begin
                    $error("text_done: expected %b, got %b", want.text_done, result.text_done);
                    mismatch_count++;
                end
                if (result.replaced !== want.replaced)
                begin
                    $error("replaced: expected %b, got %b", want.replaced, result.replaced);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[utf8_stream_sanitizer_core] ERROR");
            $finish;
        end
    end

    initial
    begin : receiver
        int gap;
        int popped;
        popped = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = pop_burst ? 0 : $urandom_range(0, 5);
            // Stall output for a long stretch so the run queue fills up.
            if (popped == HOLD_AT_RESULT) gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            popped++;
            if (popped % 37 == 0) pop_burst = ($urandom_range(0, 2) == 0);
        end
    end

    initial
    begin : sender
        int  sent;
        bit  paused;
        sent = 0;
        paused = 1'b0;
        directed_rows = '{
            '{8'h00, 1'b0, 1'b1, 2'd1, 24'h00_0000, 1'b0},
            '{8'h7F, 1'b0, 1'b1, 2'd1, 24'h00_007F, 1'b0},
            '{8'h80, 1'b0, 1'b1, 2'd3, REPL_BYTES, 1'b1},
            '{8'hFF, 1'b0, 1'b1, 2'd3, REPL_BYTES, 1'b1},
            '{8'hF8, 1'b0, 1'b1, 2'd3, REPL_BYTES, 1'b1},
            '{8'hC2, 1'b0, 1'b1, 2'd0, 24'h00_0000, 1'b0},
            '{8'h80, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'hDF, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'hBF, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'hC1, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'hBF, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'hE0, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'hA0, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'h80, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'hED, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'hA0, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'h80, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'hF4, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'h90, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'h80, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'h80, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'hC2, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'h41, 1'b1, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'hE2, 1'b1, 1'b1, 2'd3, REPL_BYTES, 1'b1},
            '{8'hF0, 1'b0, 1'b0, 2'd0, 24'h00_0000, 1'b0},
            '{8'h90, 1'b1, 1'b1, 2'd3, REPL_BYTES, 1'b1}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_rows[i]) send_row(directed_rows[i]);
        while (sent < RANDOM_ITEMS)
        begin
            if (!paused && sent >= DRAIN_PAUSE_AT)
            begin
                // Hold input until every queued byte has come out.
                paused = 1'b1;
                push <= 1'b0;
                while (clean_bytes_q.size() != 0) @(posedge clk);
                @(posedge clk);
            end
            send_random_chunk(sent);
        end
        push <= 1'b0;
        while (clean_bytes_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[utf8_stream_sanitizer_core] OK");
        else
            $display("[utf8_stream_sanitizer_core] ERROR");
        $finish;
    end

endmodule
